// ----- src/mtf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Move-to-front tracker package
// Shared sizes and store layout for the move-to-front position tracker.
// ----------------------------------------------------------------------------
package mtf_pkg;

  // largest number of list items
  localparam int MAX_ITEMS = 64;
  // width of every item field on the ports
  localparam int FIELD_W   = 7;
  // store address and stored position widths
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int POS_W     = $clog2(MAX_ITEMS + 1);
  // store word: {accessed, max_position, position}
  localparam int WORD_W    = 2 * POS_W + 1;

  // request codes
  localparam logic REQ_ACCESS  = 1'b0;
  localparam logic REQ_READOUT = 1'b1;

  typedef struct packed {
    logic             accessed;
    logic [POS_W-1:0] max_pos;
    logic [POS_W-1:0] pos;
  } entry_t;

endpackage : mtf_pkg
`default_nettype wire

// ----- src/mtf_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Move-to-front tracker channels
// Valid/ready channels for requests, results and the list size register.
// ----------------------------------------------------------------------------
interface mtf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [mtf_pkg::FIELD_W-1:0] item_id;

  modport source (output valid, req_type, item_id, input ready);
  modport sink   (input valid, req_type, item_id, output ready);
endinterface : mtf_in_if

interface mtf_out_if;
  logic                        valid;
  logic                        ready;
  logic [mtf_pkg::FIELD_W-1:0] position;
  logic [mtf_pkg::FIELD_W-1:0] min_position;
  logic [mtf_pkg::FIELD_W-1:0] max_position;

  modport source (output valid, position, min_position, max_position, input ready);
  modport sink   (input valid, position, min_position, max_position, output ready);
endinterface : mtf_out_if

interface mtf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mtf_pkg::FIELD_W-1:0] list_size;

  modport source (output valid, list_size, input ready);
  modport sink   (input valid, list_size, output ready);
endinterface : mtf_cfg_if
`default_nettype wire

// ----- src/mtf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : mtf_ram
`default_nettype wire

// ----- src/move_to_front_position_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Move-to-front position tracker
// Keeps a move-to-front list in one entry store; an access walks every list entry
// through one shared compare/increment unit, a readout reads one entry.
// ----------------------------------------------------------------------------
// An access passes LOOK, a WALK over the list entries, FIN and EMIT; a readout
// passes LOOK and EMIT; an item out of range goes straight to EMIT. The block takes
// one item at a time; an access walks one entry per cycle through the store's
// read and write ports, and EMIT waits until the output register is free.
// Reset and a list_size write clear the per-entry valid bits at once, which
// puts the list back in identity order; no clearing pass is needed.
module move_to_front_position_tracker (
  input wire logic clk,
  input wire logic rst_n,
  mtf_in_if.sink   in_chan,
  mtf_out_if.source out_chan,
  mtf_cfg_if.sink  cfg_chan
);
  import mtf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam logic [FIELD_W-1:0] SIZE_MAX = FIELD_W'(MAX_ITEMS);

  logic [2:0]           state_r, state_nxt;
  logic [FIELD_W-1:0]   list_size_r;
  logic [MAX_ITEMS-1:0] valid_r;
  logic                 req_r;
  logic [FIELD_W-1:0]   id_r;
  logic [IDX_W-1:0]     idx_r;
  logic [POS_W-1:0]     p_r, mxi_r;
  logic [IDX_W-1:0]     rd_addr_r;
  logic [FIELD_W-1:0]   res_pos_r, res_min_r, res_max_r;
  logic                 out_valid_r;
  logic [FIELD_W-1:0]   out_pos_r, out_min_r, out_max_r;

  // store ports
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wentry, rentry, eff;
  logic [WORD_W-1:0] rdata;

  logic in_acc, cfg_acc, out_free, in_range, last_entry;
  logic [POS_W-1:0] rst_pos, bumped, fin_max, rd_max;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = (state_r == ST_IDLE);
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign cfg_acc  = cfg_chan.valid && cfg_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_range = (in_chan.item_id != '0) && (in_chan.item_id <= list_size_r);
  assign last_entry = (rd_addr_r == IDX_W'(list_size_r - FIELD_W'(1)));

  assign out_chan.valid        = out_valid_r;
  assign out_chan.position     = out_pos_r;
  assign out_chan.min_position = out_min_r;
  assign out_chan.max_position = out_max_r;

  mtf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entry seen by the logic: an entry never written holds its reset value
  assign rentry  = entry_t'(rdata);
  assign rst_pos = POS_W'(rd_addr_r) + POS_W'(1);
  always_comb begin
    if (valid_r[rd_addr_r]) begin
      eff = rentry;
    end else begin
      eff.accessed = 1'b0;
      eff.max_pos  = rst_pos;
      eff.pos      = rst_pos;
    end
  end

  // shared compare/increment unit
  assign bumped  = eff.pos + POS_W'(1);
  assign fin_max = (p_r > mxi_r) ? p_r : mxi_r;
  assign rd_max  = (eff.pos > eff.max_pos) ? eff.pos : eff.max_pos;

  // read address selection
  always_comb begin
    case (state_r)
      ST_IDLE: raddr = IDX_W'(in_chan.item_id - FIELD_W'(1));
      ST_LOOK: raddr = '0;
      ST_WALK: raddr = rd_addr_r + IDX_W'(1);
      default: raddr = rd_addr_r;
    endcase
  end

  // store write: bump entries in front of the accessed one, then the item
  always_comb begin
    we             = 1'b0;
    waddr          = rd_addr_r;
    wentry.accessed = eff.accessed;
    wentry.pos      = bumped;
    wentry.max_pos  = (bumped > eff.max_pos) ? bumped : eff.max_pos;
    case (state_r)
      ST_WALK: begin
        we = (rd_addr_r != idx_r) && (eff.pos < p_r);
      end
      ST_FIN: begin
        we              = 1'b1;
        waddr           = idx_r;
        wentry.accessed = 1'b1;
        wentry.pos      = POS_W'(1);
        wentry.max_pos  = fin_max;
      end
      default: we = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_range ? ST_LOOK : ST_EMIT;
        end
      end
      ST_LOOK: state_nxt = (req_r == REQ_READOUT) ? ST_EMIT : ST_WALK;
      ST_WALK: begin
        if (last_entry) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      list_size_r <= SIZE_MAX;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        valid_r <= '0;
        if (cfg_chan.list_size == '0) begin
          list_size_r <= FIELD_W'(1);
        end else if (cfg_chan.list_size > SIZE_MAX) begin
          list_size_r <= SIZE_MAX;
        end else begin
          list_size_r <= cfg_chan.list_size;
        end
      end else if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_addr_r <= raddr;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_r     <= in_chan.req_type;
          id_r      <= in_chan.item_id;
          idx_r     <= raddr;
          res_pos_r <= '0;
          res_min_r <= '0;
          res_max_r <= '0;
        end
      end
      ST_LOOK: begin
        p_r       <= eff.pos;
        mxi_r     <= eff.max_pos;
        res_pos_r <= FIELD_W'(eff.pos);
        res_min_r <= eff.accessed ? FIELD_W'(1) : id_r;
        res_max_r <= FIELD_W'(rd_max);
      end
      ST_FIN: begin
        res_pos_r <= FIELD_W'(p_r);
        res_min_r <= FIELD_W'(1);
        res_max_r <= FIELD_W'(fin_max);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_pos_r <= res_pos_r;
          out_min_r <= res_min_r;
          out_max_r <= res_max_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule : move_to_front_position_tracker
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Move-to-front position tracker testbench
// Drives moves and readouts through the request channel and changes the list
// size between phases. Each result is checked against a move-to-front list
// kept inside the bench, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  import mtf_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  // leave margin for the longest walk before a size change
  localparam int SETTLE_CYCLES = 2 * MAX_ITEMS + 16;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] item_id;
  } mtf_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] min_position;
    logic [FIELD_W-1:0] max_position;
  } mtf_res_t;

  logic clk = 1'b0;
  logic rst_n;

  mtf_in_if  in_chan ();
  mtf_out_if out_chan ();
  mtf_cfg_if cfg_chan ();

  move_to_front_position_tracker u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bench copy of the list
  int               list_len;
  logic [POS_W-1:0] list_pos   [MAX_ITEMS];
  logic [POS_W-1:0] list_peak  [MAX_ITEMS];
  logic             list_touched [MAX_ITEMS];

  mtf_req_t request_queue [$];
  mtf_res_t expected_positions [$];

  logic     in_taken;
  mtf_req_t next_req;
  int       cycle_cnt;
  int       fail_cnt;
  int       items_taken;
  int       results_seen;
  int       move_cnt;
  int       readout_cnt;
  int       unknown_cnt;
  int       size_writes;

  // queue helpers: append at the tail
  function automatic void add_request(input mtf_req_t r);
    request_queue.insert(request_queue.size(), r);
  endfunction

  function automatic void add_expected(input mtf_res_t e);
    expected_positions.insert(expected_positions.size(), e);
  endfunction

  function automatic int clamp_len(input logic [FIELD_W-1:0] v);
    if (v < 1)
      return 1;
    if (v > MAX_ITEMS)
      return MAX_ITEMS;
    return int'(v);
  endfunction

  // list size write: clamp and go back to identity order
  function automatic void load_list_size(input logic [FIELD_W-1:0] v);
    list_len = clamp_len(v);
    for (int k = 0; k < MAX_ITEMS; k++) begin
      list_pos[k]     = POS_W'(k + 1);
      list_peak[k]    = POS_W'(k + 1);
      list_touched[k] = 1'b0;
    end
  endfunction

  // apply one request to the bench list and return the result it gives
  function automatic mtf_res_t track_request(input mtf_req_t r);
    mtf_res_t         res;
    int               idx;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] top;
    res = '0;
    if (r.item_id == 0 || int'(r.item_id) > list_len) begin
      unknown_cnt++;
      return res;
    end
    idx = int'(r.item_id) - 1;
    if (r.req_type == REQ_ACCESS) begin
      move_cnt++;
      p = list_pos[idx];
      // everything in front of the item slides back one place
      for (int k = 0; k < list_len; k++) begin
        if (k != idx && list_pos[k] < p) begin
          list_pos[k] = list_pos[k] + 1'b1;
          if (list_pos[k] > list_peak[k])
            list_peak[k] = list_pos[k];
        end
      end
      if (p > list_peak[idx])
        list_peak[idx] = p;
      list_pos[idx]     = POS_W'(1);
      list_touched[idx] = 1'b1;
      res.position     = FIELD_W'(p);
      res.min_position = FIELD_W'(1);
      res.max_position = FIELD_W'(list_peak[idx]);
    end else begin
      readout_cnt++;
      top = list_peak[idx];
      if (list_pos[idx] > top)
        top = list_pos[idx];
      res.position     = FIELD_W'(list_pos[idx]);
      res.min_position = list_touched[idx] ? FIELD_W'(1) : r.item_id;
      res.max_position = FIELD_W'(top);
    end
    return res;
  endfunction

  function automatic mtf_req_t make_req(input logic t, input int id);
    mtf_req_t r;
    r.req_type = t;
    r.item_id  = FIELD_W'(id);
    return r;
  endfunction

  // mostly known items, a few zero or beyond the list end
  function automatic mtf_req_t random_request(input int len);
    mtf_req_t r;
    int       roll;
    r.req_type = ($urandom_range(99) < 35) ? REQ_READOUT : REQ_ACCESS;
    roll = $urandom_range(99);
    if (roll < 3)
      r.item_id = '0;
    else if (roll < 9)
      r.item_id = FIELD_W'($urandom_range(127, len + 1));
    else
      r.item_id = FIELD_W'($urandom_range(len, 1));
    return r;
  endfunction

  // monitor: handshakes on all three channels
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cfg_chan.valid && cfg_chan.ready) begin
      load_list_size(cfg_chan.list_size);
      size_writes++;
    end
    if (in_chan.valid && in_chan.ready) begin
      add_expected(track_request({in_chan.req_type, in_chan.item_id}));
      items_taken++;
      in_taken = 1'b1;
    end
    if (out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (expected_positions.size() == 0) begin
        $error("result with no request outstanding: position %0d", out_chan.position);
        fail_cnt++;
      end else begin
        mtf_res_t exp_res;
        exp_res = expected_positions.pop_front();
        if (out_chan.position !== exp_res.position) begin
          $error("position: expected %0d, got %0d", exp_res.position, out_chan.position);
          fail_cnt++;
        end
        if (out_chan.min_position !== exp_res.min_position) begin
          $error("min_position: expected %0d, got %0d",
                 exp_res.min_position, out_chan.min_position);
          fail_cnt++;
        end
        if (out_chan.max_position !== exp_res.max_position) begin
          $error("max_position: expected %0d, got %0d",
                 exp_res.max_position, out_chan.max_position);
          fail_cnt++;
        end
      end
    end
  end

  // driver: requests and result back-pressure, changed on the falling edge
  always @(negedge clk) begin
    int send_idle;
    int recv_idle;
    if (items_taken < 500) begin
      send_idle = 18;
      recv_idle = 57;
    end else if (items_taken < 1000) begin
      send_idle = 57;
      recv_idle = 18;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if (rst_n) begin
      if (!in_chan.valid || in_taken) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_req = request_queue.pop_front();
          in_chan.valid    <= 1'b1;
          in_chan.req_type <= next_req.req_type;
          in_chan.item_id  <= next_req.item_id;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
      out_chan.ready <= ($urandom_range(99) >= recv_idle);
    end
    in_taken = 1'b0;
  end

  // wait until no request is pending or in flight and nothing is expected
  task automatic wait_drained();
    while (request_queue.size() != 0 || in_chan.valid || expected_positions.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_list_size(input logic [FIELD_W-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_chan.valid     <= 1'b1;
    cfg_chan.list_size <= v;
    @(posedge clk);
    while (!cfg_chan.ready)
      @(posedge clk);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input logic [FIELD_W-1:0] v, input int n);
    int len;
    write_list_size(v);
    len = clamp_len(v);
    repeat (n) add_request(random_request(len));
  endtask

  // timeout
  initial begin
    while (cycle_cnt < CYCLE_LIMIT)
      @(posedge clk);
    $display("testbench NOT OK");
    $finish;
  end

  // stimulus
  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.req_type   = REQ_ACCESS;
    in_chan.item_id    = '0;
    out_chan.ready     = 1'b0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.list_size = '0;
    in_taken           = 1'b0;
    cycle_cnt          = 0;
    fail_cnt           = 0;
    items_taken        = 0;
    results_seen       = 0;
    move_cnt           = 0;
    readout_cnt        = 0;
    unknown_cnt        = 0;
    size_writes        = 0;
    load_list_size(FIELD_W'(MAX_ITEMS));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size: both ends of the list, front item, unknown items
    add_request(make_req(REQ_READOUT, 1));
    add_request(make_req(REQ_READOUT, MAX_ITEMS));
    add_request(make_req(REQ_ACCESS, MAX_ITEMS));
    add_request(make_req(REQ_ACCESS, MAX_ITEMS));   // already in front
    add_request(make_req(REQ_ACCESS, 1));
    add_request(make_req(REQ_READOUT, MAX_ITEMS));
    add_request(make_req(REQ_READOUT, 2));
    add_request(make_req(REQ_ACCESS, 0));
    add_request(make_req(REQ_READOUT, 0));
    add_request(make_req(REQ_ACCESS, MAX_ITEMS + 1));
    add_request(make_req(REQ_READOUT, 127));
    add_request(make_req(REQ_ACCESS, 127));
    add_request(make_req(REQ_ACCESS, 42));
    add_request(make_req(REQ_ACCESS, 21));
    add_request(make_req(REQ_READOUT, 42));
    add_request(make_req(REQ_READOUT, 63));

    // size zero clamps to one item
    write_list_size(FIELD_W'(0));
    add_request(make_req(REQ_READOUT, 1));
    add_request(make_req(REQ_ACCESS, 1));
    add_request(make_req(REQ_ACCESS, 2));
    add_request(make_req(REQ_READOUT, 1));
    add_request(make_req(REQ_READOUT, 2));

    // size above the maximum clamps to the full list
    write_list_size(FIELD_W'(127));
    add_request(make_req(REQ_ACCESS, MAX_ITEMS));
    add_request(make_req(REQ_READOUT, 1));

    // random phases, mostly short lists
    random_phase(FIELD_W'(127), 100);
    random_phase(FIELD_W'(2), 150);
    random_phase(FIELD_W'(5), 200);
    random_phase(FIELD_W'(1), 60);
    random_phase(FIELD_W'(9), 140);
    random_phase(FIELD_W'(0), 40);
    random_phase(FIELD_W'(16), 200);
    random_phase(FIELD_W'(MAX_ITEMS), 80);
    random_phase(FIELD_W'(3), 150);
    random_phase(FIELD_W'($urandom_range(40, 1)), 150);
    random_phase(FIELD_W'(MAX_ITEMS + 1), 60);
    random_phase(FIELD_W'($urandom_range(12, 1)), 100);

    wait_drained();
    if (expected_positions.size() != 0) begin
      $error("%0d results never arrived", expected_positions.size());
      fail_cnt++;
    end

    $display("Sent %0d requests: %0d moves, %0d readouts, %0d for unknown items.",
             items_taken, move_cnt, readout_cnt, unknown_cnt);
    $display("Checked %0d results across %0d list size writes.", results_seen, size_writes);
    if (fail_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule : testbench
